/* design/ffpa_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// First-fit partition allocator package
// Result status codes and the request type encoding.
// ---------------------------------------------------------------------------
package ffpa_pkg;
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NOFIT = 3'd1;
  localparam logic [2:0] ST_NOJOB = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam int unsigned SizeW = 17;
endpackage
`default_nettype wire

/* design/first_fit_partition_allocator.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// First-fit partition allocator
// Keeps an address-ordered partition table and a job table in registers and
// serves allocate and free requests with a small sequencer.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  request  | in        | req_valid_i/stall_o | req_type_i, job_id_i, request_size_i
//  result   | out       | res_valid_o/stall_i | status_o
//  config   | in        | pool_size_we_i      | pool_size_i
//
// A request steps through the tables one entry at a time in each scan and in
// each shift step of a split or merge.
// The job count is kept in a register. Reset and a pool_size write leave one
// free partition covering the pool. The request side is stalled from the
// accepted item until its result has been taken by the result side.
// ---------------------------------------------------------------------------
module first_fit_partition_allocator #(
  parameter int unsigned MAX_PARTITIONS = 16,
  parameter int unsigned MAX_JOBS       = 16,
  parameter int unsigned ADDR_BITS      = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       pool_size_we_i,
  input  wire logic [ffpa_pkg::SizeW-1:0] pool_size_i,
  input  wire logic                       req_valid_i,
  output logic                            stall_o,
  input  wire logic                       req_type_i,
  input  wire logic [7:0]                 job_id_i,
  input  wire logic [ffpa_pkg::SizeW-1:0] request_size_i,
  output logic                            res_valid_o,
  input  wire logic                       stall_i,
  output logic [2:0]                      status_o
);
  import ffpa_pkg::*;

  localparam int unsigned PW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned PCW = $clog2(MAX_PARTITIONS + 1);
  localparam int unsigned JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned JCW = $clog2(MAX_JOBS + 1);
  localparam int unsigned LimBits = (ADDR_BITS < 16) ? ADDR_BITS : 16;
  localparam logic [SizeW-1:0] PoolLimit = SizeW'(1) << LimBits;
  localparam int unsigned AW = ADDR_BITS;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_SCANP   = 4'd2;
  localparam logic [3:0] S_SPLIT   = 4'd3;
  localparam logic [3:0] S_SCANJ   = 4'd4;
  localparam logic [3:0] S_FINDP   = 4'd5;
  localparam logic [3:0] S_JSHIFT  = 4'd6;
  localparam logic [3:0] S_MERGEL  = 4'd7;
  localparam logic [3:0] S_MERGER  = 4'd8;
  localparam logic [3:0] S_REMOVE  = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [AW-1:0]    pstart_q [MAX_PARTITIONS];
  logic [SizeW-1:0] plen_q   [MAX_PARTITIONS];
  logic             pused_q  [MAX_PARTITIONS];
  logic [PCW-1:0]   pcount_q;
  logic [7:0]       jnum_q   [MAX_JOBS];
  logic [AW-1:0]    jstart_q [MAX_JOBS];
  logic [JCW-1:0]   jcount_q;

  logic [3:0]       state_q;
  logic             typ_q;
  logic [7:0]       id_q;
  logic [SizeW-1:0] size_q;
  logic [PCW-1:0]   pi_q;   // partition cursor
  logic [PCW-1:0]   pk_q;   // shift cursor
  logic [JCW-1:0]   ji_q;
  logic [AW-1:0]    fstart_q;
  logic             mright_q;
  logic [2:0]       status_q;

  logic [SizeW-1:0] pool_clip;
  always_comb begin
    pool_clip = pool_size_i;
    if (pool_clip == '0) pool_clip = SizeW'(1);
    if (pool_clip > PoolLimit) pool_clip = PoolLimit;
  end

  wire [PW-1:0] pi = pi_q[PW-1:0];
  wire [PW-1:0] pk = pk_q[PW-1:0];
  wire [JW-1:0] ji = ji_q[JW-1:0];

  assign stall_o     = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign status_o    = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pcount_q <= PCW'(1);
      jcount_q <= '0;
      typ_q    <= 1'b0;
      id_q     <= '0;
      size_q   <= '0;
      pi_q     <= '0;
      pk_q     <= '0;
      ji_q     <= '0;
      fstart_q <= '0;
      mright_q <= 1'b0;
      status_q <= ST_OK;
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        pstart_q[i] <= '0;
        plen_q[i]   <= (i == 0) ? PoolLimit : '0;
        pused_q[i]  <= 1'b0;
      end
      for (int i = 0; i < MAX_JOBS; i++) begin
        jnum_q[i]   <= '0;
        jstart_q[i] <= '0;
      end
    end else if (pool_size_we_i) begin
      pcount_q <= PCW'(1);
      jcount_q <= '0;
      pstart_q[0] <= '0;
      plen_q[0]   <= pool_clip;
      pused_q[0]  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            typ_q   <= req_type_i;
            id_q    <= job_id_i;
            size_q  <= request_size_i;
            pi_q    <= '0;
            ji_q    <= '0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (typ_q == REQ_FREE) begin
            state_q <= S_SCANJ;
          end else if (size_q == '0) begin
            status_q <= ST_ZERO;
            state_q  <= S_DONE;
          end else if (jcount_q >= JCW'(MAX_JOBS)) begin
            status_q <= ST_FULL;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_SCANP;
          end
        end
        S_SCANP: begin
          if (pi_q >= pcount_q) begin
            status_q <= ST_NOFIT;
            state_q  <= S_DONE;
          end else if (!pused_q[pi] && plen_q[pi] >= size_q) begin
            if (plen_q[pi] == size_q) begin
              pused_q[pi] <= 1'b1;
              jnum_q[jcount_q[JW-1:0]]   <= id_q;
              jstart_q[jcount_q[JW-1:0]] <= pstart_q[pi];
              jcount_q <= jcount_q + JCW'(1);
              status_q <= ST_OK;
              state_q  <= S_DONE;
            end else if (pcount_q >= PCW'(MAX_PARTITIONS)) begin
              status_q <= ST_FULL;
              state_q  <= S_DONE;
            end else begin
              pk_q    <= pcount_q;
              state_q <= S_SPLIT;
            end
          end else begin
            pi_q <= pi_q + PCW'(1);
          end
        end
        S_SPLIT: begin
          // Open a gap at pi+1 one entry a cycle (no pool_size write), then write the remainder.
          if (pk_q > pi_q + PCW'(1)) begin
            pstart_q[pk] <= pstart_q[PW'(pk_q - PCW'(1))];
            plen_q[pk]   <= plen_q[PW'(pk_q - PCW'(1))];
            pused_q[pk]  <= pused_q[PW'(pk_q - PCW'(1))];
            pk_q <= pk_q - PCW'(1);
          end else begin
            pstart_q[pk] <= pstart_q[pi] + AW'(size_q);
            plen_q[pk]   <= plen_q[pi] - size_q;
            pused_q[pk]  <= 1'b0;
            plen_q[pi]   <= size_q;
            pused_q[pi]  <= 1'b1;
            pcount_q <= pcount_q + PCW'(1);
            jnum_q[jcount_q[JW-1:0]]   <= id_q;
            jstart_q[jcount_q[JW-1:0]] <= pstart_q[pi];
            jcount_q <= jcount_q + JCW'(1);
            status_q <= ST_OK;
            state_q  <= S_DONE;
          end
        end
        S_SCANJ: begin
          if (ji_q >= jcount_q) begin
            status_q <= ST_NOJOB;
            state_q  <= S_DONE;
          end else if (jnum_q[ji] == id_q) begin
            fstart_q <= jstart_q[ji];
            state_q  <= S_FINDP;
          end else begin
            ji_q <= ji_q + JCW'(1);
          end
        end
        S_FINDP: begin
          if (pi_q >= pcount_q) begin
            status_q <= ST_NOJOB;
            state_q  <= S_DONE;
          end else if (pused_q[pi] && pstart_q[pi] == fstart_q) begin
            state_q <= S_JSHIFT;
          end else begin
            pi_q <= pi_q + PCW'(1);
          end
        end
        S_JSHIFT: begin
          if (ji_q + JCW'(1) < jcount_q) begin
            jnum_q[ji]   <= jnum_q[JW'(ji_q + JCW'(1))];
            jstart_q[ji] <= jstart_q[JW'(ji_q + JCW'(1))];
            ji_q <= ji_q + JCW'(1);
          end else begin
            jcount_q    <= jcount_q - JCW'(1);
            pused_q[pi] <= 1'b0;
            state_q     <= S_MERGEL;
          end
        end
        S_MERGEL: begin
          if (pi_q != '0 && !pused_q[PW'(pi_q - PCW'(1))]) begin
            plen_q[PW'(pi_q - PCW'(1))] <= plen_q[PW'(pi_q - PCW'(1))] + plen_q[pi];
            pk_q     <= pi_q;
            pi_q     <= pi_q - PCW'(1);
            mright_q <= 1'b0;
            state_q  <= S_REMOVE;
          end else begin
            state_q <= S_MERGER;
          end
        end
        S_MERGER: begin
          if (pi_q + PCW'(1) < pcount_q && !pused_q[PW'(pi_q + PCW'(1))]) begin
            plen_q[pi] <= plen_q[pi] + plen_q[PW'(pi_q + PCW'(1))];
            pk_q     <= pi_q + PCW'(1);
            mright_q <= 1'b1;
            state_q  <= S_REMOVE;
          end else begin
            status_q <= ST_OK;
            state_q  <= S_DONE;
          end
        end
        S_REMOVE: begin
          // Close the gap at pk one entry a cycle, while no pool_size write holds the sequencer.
          if (pk_q + PCW'(1) < pcount_q) begin
            pstart_q[pk] <= pstart_q[PW'(pk_q + PCW'(1))];
            plen_q[pk]   <= plen_q[PW'(pk_q + PCW'(1))];
            pused_q[pk]  <= pused_q[PW'(pk_q + PCW'(1))];
            pk_q <= pk_q + PCW'(1);
          end else begin
            pstart_q[pk] <= '0;
            plen_q[pk]   <= '0;
            pused_q[pk]  <= 1'b0;
            pcount_q <= pcount_q - PCW'(1);
            if (mright_q) begin
              status_q <= ST_OK;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_MERGER;
            end
          end
        end
        S_DONE: begin
          if (!stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
